// ===== sv/day_count_to_calendar_time_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the day count to calendar time block
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef DAY_COUNT_TO_CALENDAR_TIME_DEFINES_SVH
`define DAY_COUNT_TO_CALENDAR_TIME_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DCCT_ASSERT_NOW(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("dcct: same-cycle property failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DCCT_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("dcct: next-cycle property failed");

`endif

// ===== sv/dcct_pkg.sv =====
// ----------------------------------------------------------------------------
// dcct_pkg
// Types, constants and the month length table of the calendar converter.
// ----------------------------------------------------------------------------
package dcct_pkg;

  typedef struct packed {
    logic signed [20:0] day_count;
    logic [10:0]        minute_of_day;
    logic [11:0]        tick_count;
  } ts_t;

  typedef struct packed {
    logic [12:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } cal_t;

  // Control from the sequencer to the year tracker.
  typedef struct packed {
    logic load;
    logic step;
  } year_ctrl_t;

  localparam logic [12:0] FIRST_YEAR      = 13'd1978;
  localparam logic [1:0]  FIRST_MOD4      = 2'd2;
  localparam logic [6:0]  FIRST_MOD100    = 7'd78;
  localparam logic [8:0]  FIRST_MOD400    = 9'd378;
  localparam logic [6:0]  LAST_MOD100     = 7'd99;
  localparam logic [8:0]  LAST_MOD400     = 9'd399;

  localparam logic [8:0]  LEAP_YEAR_LEN   = 9'd366;
  localparam logic [8:0]  COMMON_YEAR_LEN = 9'd365;
  localparam logic [3:0]  LAST_MONTH      = 4'd11;

  localparam logic [10:0] LAST_MINUTE     = 11'd1439;
  localparam logic [6:0]  MAX_SECOND      = 7'd59;
  // floor(x * 2185 / 2^17) == x / 60 for x <= 1439
  localparam logic [11:0] HOUR_RECIP      = 12'd2185;
  // floor(x * 1311 / 2^16) == x / 50 for x <= 4095
  localparam logic [10:0] SEC_RECIP       = 11'd1311;

  localparam logic [3:0]  MON_FEB         = 4'd1;
  localparam logic [3:0]  MON_APR         = 4'd3;
  localparam logic [3:0]  MON_JUN         = 4'd5;
  localparam logic [3:0]  MON_SEP         = 4'd8;
  localparam logic [3:0]  MON_NOV         = 4'd10;

  // Length of month m (0 is January).
  function automatic logic [8:0] month_len(input logic [3:0] m, input logic leap);
    logic [8:0] len;
    case (m)
      MON_FEB: begin
        len = leap ? 9'd29 : 9'd28;
      end
      MON_APR, MON_JUN, MON_SEP, MON_NOV: begin
        len = 9'd30;
      end
      default: begin
        len = 9'd31;
      end
    endcase
    return len;
  endfunction

endpackage

// ===== sv/dcct_sub.sv =====
// ----------------------------------------------------------------------------
// dcct_sub
// Shared subtract and compare unit: remaining days minus a year or month length.
// ----------------------------------------------------------------------------
module dcct_sub (
  input  logic [19:0] a,
  input  logic [8:0]  b,
  output logic [19:0] diff,
  output logic        ge
);

  logic [20:0] d;

  assign d    = {1'b0, a} - {12'd0, b};
  assign diff = d[19:0];
  assign ge   = ~d[20];

endmodule

// ===== sv/dcct_year.sv =====
// ----------------------------------------------------------------------------
// dcct_year
// Year counter with running mod 4/100/400 residues for the leap test.
// ----------------------------------------------------------------------------
module dcct_year (
  input  logic                clk,
  input  logic                rst,
  input  dcct_pkg::year_ctrl_t ctrl,
  output logic [12:0]         year,
  output logic                leap
);

  logic [1:0] mod4;
  logic [6:0] mod100;
  logic [8:0] mod400;

  always_ff @(posedge clk) begin
    if (rst) begin
      year   <= dcct_pkg::FIRST_YEAR;
      mod4   <= dcct_pkg::FIRST_MOD4;
      mod100 <= dcct_pkg::FIRST_MOD100;
      mod400 <= dcct_pkg::FIRST_MOD400;
    end else if (ctrl.load) begin
      year   <= dcct_pkg::FIRST_YEAR;
      mod4   <= dcct_pkg::FIRST_MOD4;
      mod100 <= dcct_pkg::FIRST_MOD100;
      mod400 <= dcct_pkg::FIRST_MOD400;
    end else if (ctrl.step) begin
      year   <= year + 13'd1;
      mod4   <= mod4 + 2'd1;
      mod100 <= (mod100 == dcct_pkg::LAST_MOD100) ? 7'd0 : mod100 + 7'd1;
      mod400 <= (mod400 == dcct_pkg::LAST_MOD400) ? 9'd0 : mod400 + 9'd1;
    end
  end

  assign leap = (mod4 == 2'd0) && ((mod100 != 7'd0) || (mod400 == 9'd0));

endmodule

// ===== sv/dcct_tod.sv =====
// ----------------------------------------------------------------------------
// dcct_tod
// Time of day: hour, minute and second from the minute and tick counts.
// ----------------------------------------------------------------------------
module dcct_tod (
  input  logic        clk,
  input  logic        load,
  input  logic [10:0] minute_of_day,
  input  logic [11:0] tick_count,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second
);

  logic [10:0] mins_sat;
  logic [22:0] hour_prod;
  logic [22:0] sec_prod;
  logic [6:0]  sec_raw;
  logic [10:0] mins_q;
  logic [4:0]  hour_q;
  logic [5:0]  sec_q;
  logic [10:0] hour_x60;
  logic [10:0] rem;

  assign mins_sat  = (minute_of_day > dcct_pkg::LAST_MINUTE) ? dcct_pkg::LAST_MINUTE
                                                            : minute_of_day;
  assign hour_prod = 23'(mins_sat) * 23'(dcct_pkg::HOUR_RECIP);
  assign sec_prod  = 23'(tick_count) * 23'(dcct_pkg::SEC_RECIP);
  assign sec_raw   = sec_prod[22:16];

  // Payload only: capture on load, no reset needed.
  always_ff @(posedge clk) begin
    if (load) begin
      mins_q <= mins_sat;
      hour_q <= hour_prod[21:17];
      sec_q  <= (sec_raw > dcct_pkg::MAX_SECOND) ? dcct_pkg::MAX_SECOND[5:0] : sec_raw[5:0];
    end
  end

  // hour * 60 as (hour << 6) - (hour << 2)
  assign hour_x60 = ({6'd0, hour_q} << 6) - ({6'd0, hour_q} << 2);
  assign rem      = mins_q - hour_x60;

  assign hour   = hour_q;
  assign minute = rem[5:0];
  assign second = sec_q;

endmodule

// ===== sv/day_count_to_calendar_time.sv =====
// ----------------------------------------------------------------------------
// day_count_to_calendar_time
// Converts a day/minute/tick timestamp to a Gregorian date and time of day.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel ts (ts_valid/ts_ready) carries one timestamp: days since
//   1978-01-01 (signed, negative clamps to zero), minute of day and ticks at
//   50 per second. Output channel cal (cal_valid/cal_ready) carries one date
//   and time per timestamp, in order.
//   ts_ready is high only while the sequencer is idle; one transfer starts a
//   conversion and the block takes no new timestamp until it ends.
//   The sequencer strips whole years (year - 1978), then whole months; the
//   shared subtract unit removes one year or one month per cycle.
//   The result sits in an output register: while it waits for cal_ready the
//   sequencer is idle again and accepts the next timestamp. A finished date
//   then holds in the last state until the output register frees.
//   Reset (rst, synchronous) returns the sequencer to idle and drops any
//   pending result; no clearing pass is needed.
// ----------------------------------------------------------------------------
module day_count_to_calendar_time (
  input  logic          clk,
  input  logic          rst,
  input  logic          ts_valid,
  output logic          ts_ready,
  input  dcct_pkg::ts_t ts,
  output logic          cal_valid,
  input  logic          cal_ready,
  output dcct_pkg::cal_t cal
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_YEAR  = 4'b0010,
    S_MONTH = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  logic [19:0] days, days_next;
  logic [3:0]  mon, mon_next;
  logic        cal_valid_next;
  logic        cal_load;
  logic        ts_xfer;

  dcct_pkg::year_ctrl_t year_ctrl;
  logic [12:0] year;
  logic        leap;

  logic [8:0]  sub_b;
  logic [19:0] sub_diff;
  logic        sub_ge;

  logic [4:0]  tod_hour;
  logic [5:0]  tod_minute;
  logic [5:0]  tod_second;

  assign ts_ready = (state == S_IDLE);
  assign ts_xfer  = ts_valid && ts_ready;

  // Year tracker: restart at 1978 on a transfer, advance on each whole year.
  dcct_year u_year (
    .clk  (clk),
    .rst  (rst),
    .ctrl (year_ctrl),
    .year (year),
    .leap (leap)
  );

  // One subtractor serves both the year and the month walk.
  always_comb begin
    if (state == S_MONTH) begin
      sub_b = dcct_pkg::month_len(mon, leap);
    end else begin
      sub_b = leap ? dcct_pkg::LEAP_YEAR_LEN : dcct_pkg::COMMON_YEAR_LEN;
    end
  end

  dcct_sub u_sub (
    .a    (days),
    .b    (sub_b),
    .diff (sub_diff),
    .ge   (sub_ge)
  );

  // Time of day is captured at the input transfer and holds until the next.
  dcct_tod u_tod (
    .clk           (clk),
    .load          (ts_xfer),
    .minute_of_day (ts.minute_of_day),
    .tick_count    (ts.tick_count),
    .hour          (tod_hour),
    .minute        (tod_minute),
    .second        (tod_second)
  );

  // Sequencer: strip whole years, then whole months, then hand off.
  always_comb begin
    state_next     = state;
    days_next      = days;
    mon_next       = mon;
    year_ctrl.load = 1'b0;
    year_ctrl.step = 1'b0;
    cal_load       = 1'b0;
    case (state)
      S_IDLE: begin
        if (ts_valid) begin
          // Clamp a negative day count to the first day.
          days_next      = ts.day_count[20] ? 20'd0 : ts.day_count[19:0];
          mon_next       = 4'd0;
          year_ctrl.load = 1'b1;
          state_next     = S_YEAR;
        end
      end
      S_YEAR: begin
        if (sub_ge) begin
          days_next      = sub_diff;
          year_ctrl.step = 1'b1;
        end else begin
          state_next = S_MONTH;
        end
      end
      S_MONTH: begin
        if ((mon < dcct_pkg::LAST_MONTH) && sub_ge) begin
          days_next = sub_diff;
          mon_next  = mon + 4'd1;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // Hold here until the output register is free.
        if (!cal_valid || cal_ready) begin
          cal_load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cal_valid_next = cal_valid;
    if (cal_valid && cal_ready) begin
      cal_valid_next = 1'b0;
    end
    if (cal_load) begin
      cal_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cal_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cal_valid <= cal_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    days <= days_next;
    mon  <= mon_next;
  end

  // Output register: payload only, qualified by cal_valid.
  always_ff @(posedge clk) begin
    if (cal_load) begin
      cal.year         <= year;
      cal.month        <= mon + 4'd1;
      cal.day_of_month <= days[4:0] + 5'd1;
      cal.hour         <= tod_hour;
      cal.minute       <= tod_minute;
      cal.second       <= tod_second;
    end
  end

endmodule

// ===== sv/dcct_checker.sv =====
// ----------------------------------------------------------------------------
// dcct_checker
// Port-level checks of the calendar converter, bound to the top level.
// ----------------------------------------------------------------------------
`include "day_count_to_calendar_time_defines.svh"

module dcct_checker (
  input logic           clk,
  input logic           rst,
  input logic           ts_valid,
  input logic           ts_ready,
  input dcct_pkg::ts_t  ts,
  input logic           cal_valid,
  input logic           cal_ready,
  input dcct_pkg::cal_t cal
);

  // A stalled result holds.
  `DCCT_ASSERT_NEXT(a_cal_hold, cal_valid && !cal_ready, cal_valid && $stable(cal))

  // A timestamp transfer makes the input side busy in the next cycle.
  `DCCT_ASSERT_NEXT(a_busy_after_xfer, ts_valid && ts_ready, !ts_ready)

  // No result can appear in the cycle right after a timestamp transfer.
  `DCCT_ASSERT_NEXT(a_no_instant_result, ts_valid && ts_ready && !cal_valid, !cal_valid)

  // Date fields stay in calendar range.
  `DCCT_ASSERT_NOW(a_date_range, cal_valid, (cal.month >= 4'd1) && (cal.month <= 4'd12) && (cal.day_of_month >= 5'd1) && (cal.year >= 13'd1978))

  // Time fields stay in clock range.
  `DCCT_ASSERT_NOW(a_time_range, cal_valid, (cal.hour <= 5'd23) && (cal.minute <= 6'd59) && (cal.second <= 6'd59))

endmodule

bind day_count_to_calendar_time dcct_checker u_dcct_checker (.*);
